// ===== rtl/hrip_pkg.sv =====
// ----------------------------------------------------------------------------
// HID report item parser package
// Beat types, parse state and item codes shared by the parser modules.
// ----------------------------------------------------------------------------
package hrip_pkg;

  localparam logic [7:0] LONG_HEAD          = 8'hFE;
  localparam logic [3:0] TAG_COLLECTION     = 4'hA;
  localparam logic [3:0] TAG_END_COLLECTION = 4'hC;
  localparam logic [1:0] CLASS_MAIN         = 2'd0;
  localparam logic [2:0] CLASS_LONG         = 3'd4;
  localparam logic [3:0] DEPTH_LIMIT        = 4'd15;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STRAY_END = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HEAD       = 3'd0,
    PH_SHORT_DATA = 3'd1,
    PH_LONG_SIZE  = 3'd2,
    PH_LONG_TAG   = 3'd3,
    PH_LONG_DATA  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  item_class;
    logic [7:0]  item_tag;
    logic [7:0]  data_size;
    logic [31:0] data_value;
    logic [3:0]  nesting_depth;
    logic [1:0]  status;
    logic        end_of_descriptor;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  bytes_remaining;
    logic [31:0] value_acc;
    logic [7:0]  saved_head;
    logic [7:0]  long_tag;
    logic [7:0]  long_size;
    logic [3:0]  depth;
  } parse_state_t;

  // Size code 3 means four data bytes.
  function automatic logic [2:0] short_size(input logic [7:0] head);
    short_size = (head[1:0] == 2'd3) ? 3'd4 : {1'b0, head[1:0]};
  endfunction

endpackage

// ===== rtl/hrip_step.sv =====
// ----------------------------------------------------------------------------
// HID report item parser step
// Next parse state and optional result for one descriptor byte.
// ----------------------------------------------------------------------------
module hrip_step #(
  parameter logic [3:0] DEPTH_CAP = 4'd15
) (
  input  hrip_pkg::parse_state_t cur_i,
  input  hrip_pkg::in_item_t     item_i,
  output hrip_pkg::parse_state_t nxt_o,
  output logic                   emit_o,
  output hrip_pkg::out_item_t    res_o
);

  logic [7:0]  b;
  logic        last;
  logic        fin_short;
  logic        trunc;
  logic [1:0]  k;
  logic [2:0]  ssz;
  logic [7:0]  h;
  logic [31:0] acc_v;
  logic [7:0]  rem_dec;

  assign b    = item_i.data_byte;
  assign last = item_i.last_byte;

  always_comb begin
    nxt_o     = cur_i;
    emit_o    = 1'b0;
    res_o     = '0;
    fin_short = 1'b0;
    trunc     = 1'b0;
    k         = '0;
    acc_v     = cur_i.value_acc;
    rem_dec   = cur_i.bytes_remaining - 8'd1;
    ssz       = hrip_pkg::short_size(cur_i.saved_head);

    case (cur_i.phase)
      hrip_pkg::PH_SHORT_DATA: begin
        // byte position from the count already taken
        k = ssz[1:0] - cur_i.bytes_remaining[1:0];
        acc_v = cur_i.value_acc | (32'(b) << {k, 3'b000});
        nxt_o.value_acc = acc_v;
        nxt_o.bytes_remaining = rem_dec;
        if (rem_dec == 8'd0) begin
          fin_short = 1'b1;
        end else if (last) begin
          trunc = 1'b1;
        end
      end
      hrip_pkg::PH_LONG_SIZE: begin
        nxt_o.long_size = b;
        nxt_o.phase = hrip_pkg::PH_LONG_TAG;
        if (last) begin
          emit_o = 1'b1;
          res_o.item_class = hrip_pkg::CLASS_LONG;
          res_o.data_size = b;
          res_o.status = hrip_pkg::ST_TRUNCATED;
          res_o.end_of_descriptor = 1'b1;
        end
      end
      hrip_pkg::PH_LONG_TAG: begin
        nxt_o.long_tag = b;
        res_o.item_class = hrip_pkg::CLASS_LONG;
        res_o.item_tag = b;
        res_o.data_size = cur_i.long_size;
        if (cur_i.long_size == 8'd0) begin
          emit_o = 1'b1;
          res_o.status = hrip_pkg::ST_OK;
          res_o.end_of_descriptor = last;
        end else begin
          nxt_o.bytes_remaining = cur_i.long_size;
          nxt_o.phase = hrip_pkg::PH_LONG_DATA;
          if (last) begin
            emit_o = 1'b1;
            res_o.status = hrip_pkg::ST_TRUNCATED;
            res_o.end_of_descriptor = 1'b1;
          end
        end
      end
      hrip_pkg::PH_LONG_DATA: begin
        // drop long item payload bytes
        nxt_o.bytes_remaining = rem_dec;
        res_o.item_class = hrip_pkg::CLASS_LONG;
        res_o.item_tag = cur_i.long_tag;
        res_o.data_size = cur_i.long_size;
        if (rem_dec == 8'd0) begin
          emit_o = 1'b1;
          res_o.status = hrip_pkg::ST_OK;
          res_o.end_of_descriptor = last;
        end else if (last) begin
          emit_o = 1'b1;
          res_o.status = hrip_pkg::ST_TRUNCATED;
          res_o.end_of_descriptor = 1'b1;
        end
      end
      default: begin
        if (b == hrip_pkg::LONG_HEAD) begin
          nxt_o.long_size = 8'd0;
          nxt_o.long_tag = 8'd0;
          nxt_o.phase = hrip_pkg::PH_LONG_SIZE;
          if (last) begin
            emit_o = 1'b1;
            res_o.item_class = hrip_pkg::CLASS_LONG;
            res_o.status = hrip_pkg::ST_TRUNCATED;
            res_o.end_of_descriptor = 1'b1;
          end
        end else begin
          nxt_o.saved_head = b;
          acc_v = '0;
          nxt_o.value_acc = '0;
          nxt_o.bytes_remaining = {5'b0, hrip_pkg::short_size(b)};
          if (hrip_pkg::short_size(b) == 3'd0) begin
            fin_short = 1'b1;
          end else if (last) begin
            trunc = 1'b1;
          end else begin
            nxt_o.phase = hrip_pkg::PH_SHORT_DATA;
          end
        end
      end
    endcase

    h = nxt_o.saved_head;
    if (fin_short || trunc) begin
      emit_o = 1'b1;
      res_o.item_class = {1'b0, h[3:2]};
      res_o.item_tag = {4'b0, h[7:4]};
      res_o.data_size = {5'b0, hrip_pkg::short_size(h)};
      res_o.data_value = acc_v;
      res_o.status = hrip_pkg::ST_OK;
      res_o.end_of_descriptor = last;
      if (trunc) begin
        res_o.status = hrip_pkg::ST_TRUNCATED;
        res_o.end_of_descriptor = 1'b1;
      end else if (h[3:2] == hrip_pkg::CLASS_MAIN) begin
        if (h[7:4] == hrip_pkg::TAG_COLLECTION) begin
          if (cur_i.depth >= DEPTH_CAP) begin
            res_o.status = hrip_pkg::ST_SATURATED;
          end else begin
            nxt_o.depth = cur_i.depth + 4'd1;
          end
        end else if (h[7:4] == hrip_pkg::TAG_END_COLLECTION) begin
          if (cur_i.depth == 4'd0) begin
            res_o.status = hrip_pkg::ST_STRAY_END;
          end else begin
            nxt_o.depth = cur_i.depth - 4'd1;
          end
        end
      end
    end

    res_o.nesting_depth = cur_i.depth;

    if (emit_o) begin
      nxt_o.phase = hrip_pkg::PH_HEAD;
      // last byte: start the next descriptor from scratch
      if (res_o.end_of_descriptor) begin
        nxt_o.bytes_remaining = 8'd0;
        nxt_o.depth = 4'd0;
      end
    end
  end

endmodule

// ===== rtl/hid_report_item_parser_unit.sv =====
// ----------------------------------------------------------------------------
// HID report item parser unit
// Splits a HID report descriptor byte stream into items with depth and status.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry one descriptor byte per beat, with
//   last_byte set on the final byte of a descriptor.
//   out_valid/out_stall/out_item carry one beat per completed item: class,
//   tag, size, little-endian short data, nesting depth and status.
//   A byte that completes an item (or ends the descriptor) gives one result;
//   other bytes give none.
//   A result is registered: the byte lands in the input register when it is
//   accepted, and the parse step loads the result register from it once
//   the result register is empty or being taken.
//   Throughput: one byte per cycle while out_stall is low, set by the parse
//   step that updates the state register between input and result registers.
//   The input register is freed whenever the result register is empty or
//   being taken, so a waiting result does not block the next byte.
//   When out_stall holds, the result holds and at most one more byte is
//   buffered, after which in_stall rises.
//   Reset empties both registers and returns the parser to expect a head
//   byte at depth zero. The last byte of a descriptor returns the parser there too.
// ----------------------------------------------------------------------------
module hid_report_item_parser_unit #(
  parameter int unsigned MAX_DEPTH = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrip_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hrip_pkg::out_item_t out_item
);

  localparam logic [3:0] DEPTH_CAP =
    (MAX_DEPTH < 15) ? 4'(MAX_DEPTH) : hrip_pkg::DEPTH_LIMIT;

  logic                   in_vld_r;
  hrip_pkg::in_item_t     in_item_r;
  logic                   out_vld_r;
  hrip_pkg::out_item_t    out_item_r;
  hrip_pkg::parse_state_t state_r;
  hrip_pkg::parse_state_t state_nxt;
  hrip_pkg::out_item_t    res;
  logic                   emit;
  logic                   advance;

  assign advance   = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  hrip_step #(
    .DEPTH_CAP (DEPTH_CAP)
  ) u_step (
    .cur_i  (state_r),
    .item_i (in_item_r),
    .nxt_o  (state_nxt),
    .emit_o (emit),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '{phase: hrip_pkg::PH_HEAD, default: '0};
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r && emit;
        if (in_vld_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (advance && in_vld_r && emit) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== tb/tb_hid_report_item_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench: HID report item parser unit
// Streams hand-built and random report descriptors through the parser, byte
// by byte. A software parse of each accepted byte predicts the item beats,
// and every beat on the result channel is checked field by field. Both
// channels idle and stall at random, in phases.
// ----------------------------------------------------------------------------
module tb_hid_report_item_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hrip_pkg::*;

  localparam int unsigned MAX_DEPTH    = 15;
  localparam int unsigned DEPTH_CAP    = (MAX_DEPTH < 15) ? MAX_DEPTH : 15;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Parses the descriptor stream in software and queues the items it yields.
  class item_scoreboard;
    out_item_t   expected_items[$];
    int unsigned mismatch_count;
    int unsigned items_seen;
    int unsigned long_items;
    int unsigned status_seen[4];
    logic [3:0]  deepest;
    phase_t      phase;
    logic [7:0]  bytes_left;
    logic [7:0]  head;
    logic [7:0]  long_tag;
    logic [7:0]  long_size;
    logic [31:0] value_acc;
    logic [3:0]  depth;

    function new();
      phase      = PH_HEAD;
      bytes_left = '0;
      head       = '0;
      long_tag   = '0;
      long_size  = '0;
      value_acc  = '0;
      depth      = '0;
      deepest    = '0;
    endfunction

    function logic [7:0] declared_len(logic [7:0] h);
      return (h[1:0] == 2'b11) ? 8'd4 : {6'b0, h[1:0]};
    endfunction

    function void emit_item(output out_item_t res, input logic [2:0] cls,
                            input logic [7:0] tag, input logic [7:0] size,
                            input logic [31:0] value, input logic [3:0] at_depth,
                            input status_t st, input logic eod);
      res.item_class        = cls;
      res.item_tag          = tag;
      res.data_size         = size;
      res.data_value        = value;
      res.nesting_depth     = at_depth;
      res.status            = st;
      res.end_of_descriptor = eod;
      // the final byte starts a fresh descriptor
      if (eod) begin
        phase      = PH_HEAD;
        bytes_left = '0;
        depth      = '0;
      end else if (st != ST_TRUNCATED) begin
        phase = PH_HEAD;
      end
    endfunction

    function void close_short(output out_item_t res, input logic eod);
      logic [1:0] cls;
      logic [3:0] tag;
      logic [3:0] at_depth;
      status_t    st;
      cls      = head[3:2];
      tag      = head[7:4];
      at_depth = depth;
      st       = ST_OK;
      if (cls == CLASS_MAIN && tag == TAG_COLLECTION) begin
        if (depth >= DEPTH_CAP) st = ST_SATURATED;
        else depth = depth + 4'd1;
      end else if (cls == CLASS_MAIN && tag == TAG_END_COLLECTION) begin
        if (depth == 4'd0) st = ST_STRAY_END;
        else depth = depth - 4'd1;
      end
      phase = PH_HEAD;
      emit_item(res, {1'b0, cls}, {4'b0, tag}, declared_len(head), value_acc,
                at_depth, st, eod);
    endfunction

    function void cut_short(output out_item_t res);
      emit_item(res, {1'b0, head[3:2]}, {4'b0, head[7:4]}, declared_len(head),
                value_acc, depth, ST_TRUNCATED, 1'b1);
    endfunction

    // Returns 1 when the byte completes an item or ends the descriptor; res then holds it.
    function bit parse_byte(input in_item_t beat, output out_item_t res);
      logic [7:0] b;
      logic       last;
      logic [1:0] lane;
      b    = beat.data_byte;
      last = beat.last_byte;
      res  = '0;
      case (phase)
        PH_SHORT_DATA: begin
          lane = 2'(declared_len(head) - bytes_left);
          value_acc |= 32'(b) << (8 * lane);
          bytes_left--;
          if (bytes_left == 8'd0) begin
            close_short(res, last);
            return 1;
          end
          if (last) begin
            cut_short(res);
            return 1;
          end
          return 0;
        end
        PH_LONG_SIZE: begin
          long_size = b;
          phase     = PH_LONG_TAG;
          if (last) begin
            emit_item(res, CLASS_LONG, 8'd0, long_size, '0, depth, ST_TRUNCATED, 1'b1);
            return 1;
          end
          return 0;
        end
        PH_LONG_TAG: begin
          long_tag = b;
          if (long_size == 8'd0) begin
            emit_item(res, CLASS_LONG, long_tag, 8'd0, '0, depth, ST_OK, last);
            return 1;
          end
          bytes_left = long_size;
          phase      = PH_LONG_DATA;
          if (last) begin
            emit_item(res, CLASS_LONG, long_tag, long_size, '0, depth, ST_TRUNCATED, 1'b1);
            return 1;
          end
          return 0;
        end
        PH_LONG_DATA: begin
          bytes_left--;
          if (bytes_left == 8'd0) begin
            emit_item(res, CLASS_LONG, long_tag, long_size, '0, depth, ST_OK, last);
            return 1;
          end
          if (last) begin
            emit_item(res, CLASS_LONG, long_tag, long_size, '0, depth, ST_TRUNCATED, 1'b1);
            return 1;
          end
          return 0;
        end
        default: begin
          if (b == LONG_HEAD) begin
            long_size = '0;
            long_tag  = '0;
            phase     = PH_LONG_SIZE;
            if (last) begin
              emit_item(res, CLASS_LONG, 8'd0, 8'd0, '0, depth, ST_TRUNCATED, 1'b1);
              return 1;
            end
            return 0;
          end
          head       = b;
          value_acc  = '0;
          bytes_left = declared_len(b);
          if (bytes_left == 8'd0) begin
            close_short(res, last);
            return 1;
          end
          if (last) begin
            cut_short(res);
            return 1;
          end
          phase = PH_SHORT_DATA;
          return 0;
        end
      endcase
    endfunction

    function void note_byte(in_item_t beat);
      out_item_t want;
      if (parse_byte(beat, want)) expected_items.push_back(want);
    endfunction

    task report_mismatch(string msg);
      // keep the log short; the count still covers every mismatch
      if (mismatch_count < 100) $display("%t MISMATCH item %0d: %s", $realtime, items_seen, msg);
      mismatch_count++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_items.size() == 0) begin
        report_mismatch($sformatf("item beat %h with nothing pending", got));
        return;
      end
      want = expected_items.pop_front();
      items_seen++;
      status_seen[want.status]++;
      if (want.item_class == CLASS_LONG) long_items++;
      if (want.nesting_depth > deepest) deepest = want.nesting_depth;
      compare_field("item_class", got.item_class, want.item_class);
      compare_field("item_tag", got.item_tag, want.item_tag);
      compare_field("data_size", got.data_size, want.data_size);
      compare_field("data_value", got.data_value, want.data_value);
      compare_field("nesting_depth", got.nesting_depth, want.nesting_depth);
      compare_field("status", got.status, want.status);
      compare_field("end_of_descriptor", got.end_of_descriptor, want.end_of_descriptor);
    endtask
  endclass

  item_scoreboard board = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_request  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned descriptors   = 0;
  int unsigned quiet_cycles  = 0;

  int unsigned idle_by_phase[4]  = '{0, 51, 0, 35};
  int unsigned stall_by_phase[4] = '{0, 0, 51, 35};

  // {last_byte, data_byte}
  logic [8:0] directed_beats[27] = '{
    9'h0A1, 9'h001,                          // Collection, depth rises
    9'h005, 9'h0FF,                          // global, one byte
    9'h00B, 9'h078, 9'h056, 9'h034, 9'h012,  // local, four bytes
    9'h00D, 9'h0FF,                          // reserved class
    9'h0FE, 9'h001, 9'h000, 9'h05A,          // long item with one data byte
    9'h0FE, 9'h000, 9'h0FF,                  // long item with no data
    9'h000,                                  // main, no data
    9'h1C0,                                  // End Collection on the final byte
    9'h0C0,                                  // stray End Collection
    9'h109,                                  // final byte is a head that wants data
    9'h1FE,                                  // final byte is a long head
    9'h0FE, 9'h105,                          // final byte is a long size
    9'h026, 9'h101                           // final byte inside short data
  };

  hid_report_item_parser_unit #(.MAX_DEPTH(MAX_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_item);
      if (in_valid && !in_stall) board.note_byte(in_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a beat", QUIET_LIMIT);
      $display("tb_hid_report_item_parser_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, or one long hold when asked.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_item.data_byte = b;
    in_item.last_byte = last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Drop valid and hold off until every pending item has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.expected_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_item(ref logic [7:0] q[$]);
    int unsigned pick;
    int unsigned n;
    logic [7:0]  h;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // mostly short long items, a rare big one
      n = ($urandom_range(29) == 0) ? $urandom_range(5, 255) : $urandom_range(4);
      q.push_back(LONG_HEAD);
      q.push_back(8'(n));
      q.push_back(8'($urandom));
      repeat (n) q.push_back(8'($urandom));
    end else if (pick < 17) begin
      q.push_back(8'($urandom));
    end else begin
      if (pick < 37) h = {TAG_COLLECTION, CLASS_MAIN, 2'($urandom)};
      else if (pick < 55) h = {TAG_END_COLLECTION, CLASS_MAIN, 2'($urandom)};
      else h = 8'($urandom);
      q.push_back(h);
      if (h != LONG_HEAD) repeat (board.declared_len(h)) q.push_back(8'($urandom));
    end
  endtask

  task automatic send_descriptor();
    logic [7:0]  q[$];
    int unsigned cut;
    // now and then nest deeply, often past the depth limit
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(14, 19)) q.push_back({TAG_COLLECTION, CLASS_MAIN, 2'b00});
    repeat ($urandom_range(1, 12)) add_item(q);
    cut = q.size();
    if ($urandom_range(3) == 0) cut = $urandom_range(1, q.size());
    for (int i = 0; i < cut; i++) send_byte(q[i], i == cut - 1);
    descriptors++;
  endtask

  initial begin
    int unsigned target;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      if (ph == 2) begin
        wait_drained();
        // fill the block while the result side is held
        hold_request = LONG_HOLD;
      end
      target = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) send_descriptor();
    end

    wait_drained();
    $display("run: %0d bytes in %0d descriptors, %0d items (%0d long), deepest nesting %0d",
             bytes_sent, descriptors, board.items_seen, board.long_items, board.deepest);
    $display("run: status ok %0d, stray end %0d, truncated %0d, saturated %0d",
             board.status_seen[ST_OK], board.status_seen[ST_STRAY_END],
             board.status_seen[ST_TRUNCATED], board.status_seen[ST_SATURATED]);
    if (board.mismatch_count == 0) begin
      $display("tb_hid_report_item_parser_unit passed");
    end else begin
      $display("tb_hid_report_item_parser_unit failed");
    end
    $finish;
  end

endmodule

// ===== hid_report_item_parser_unit.f =====
rtl/hrip_pkg.sv
rtl/hrip_step.sv
rtl/hid_report_item_parser_unit.sv
tb/tb_hid_report_item_parser_unit.sv
